[design/ikw_pkg.sv]
// Package for the interpolation kernel weight block.
// Holds the kernel codes, field widths and the fixed-point constants of the datapath.
// Depends on nothing; every other file of the block imports it.
package ikw_pkg;

  // Fraction bits of the sample offset and of the weight.
  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;

  // Field widths.
  localparam int IN_W  = 14;
  localparam int OUT_W = 16;
  localparam int SEL_W = 3;

  // Datapath widths.
  localparam int A_W  = IN_W;                    // |x|, up to 2^(IN_W-1)
  localparam int SQ_W = 2 * A_W;                 // square of |x| or of 2 - |x|
  localparam int C_W  = IN_FRAC_BITS + 6;        // signed coefficient of the square
  localparam int P_W  = 3 * IN_FRAC_BITS + 8;    // numerator over the common divisor
  localparam int DEN_SHIFT = 3 * IN_FRAC_BITS - OUT_FRAC_BITS;
  localparam int Y_W  = P_W - DEN_SHIFT;         // numerator after the power-of-two part
  localparam int H_W  = Y_W - 1;                 // after the factor of two in six
  localparam int Q_W  = OUT_FRAC_BITS + 4;       // magnitude of the rounded weight

  // Exact divide by three: floor(h * RECIP3 / 2^RECIP3_SHIFT) for h < 2^RECIP3_SHIFT.
  localparam int RECIP3_SHIFT = 19;
  localparam int RECIP3       = ((1 << RECIP3_SHIFT) + 2) / 3;
  localparam int DIV_W        = H_W + RECIP3_SHIFT;

  // Unit of x, and the Bell scale that puts its divisor onto 6 * 2^DEN_SHIFT.
  localparam int S      = 1 << IN_FRAC_BITS;
  localparam int BELL_K = 6 << (IN_FRAC_BITS - 4);

  // Saturation limit of the weight.
  localparam int SAT_LIM = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);

  // Rounding offset: half of the common divisor 6 * 2^DEN_SHIFT.
  localparam logic signed [P_W-1:0] HALF_DEN = P_W'(3) <<< DEN_SHIFT;

  // Constant terms of the polynomials, all over the common divisor.
  localparam logic signed [P_W-1:0] CR_IN_OFF   = P_W'(6) <<< (3 * IN_FRAC_BITS);
  localparam logic signed [P_W-1:0] BS_IN_OFF   = P_W'(4) <<< (3 * IN_FRAC_BITS);
  localparam logic signed [P_W-1:0] BELL_IN_OFF = P_W'(12 * BELL_K) <<< (2 * IN_FRAC_BITS);

  // Coefficients of the Bell pieces.
  localparam logic signed [C_W-1:0] BELL_IN_C  = C_W'(-9 * BELL_K);
  localparam logic signed [C_W-1:0] BELL_OUT_C = C_W'((9 * BELL_K) / 2);

  typedef enum logic [SEL_W-1:0] {
    KERN_ZERO    = 3'd0,
    KERN_CATROM  = 3'd1,
    KERN_BELL    = 3'd2,
    KERN_BSPLINE = 3'd3,
    KERN_TRI     = 3'd4
  } kernel_e;

endpackage

[design/ikw_offset_if.sv]
// Input channel of the kernel weight block: one sample offset per word.
// Depends on ikw_pkg for the field width.
interface ikw_offset_if
  import ikw_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample_offset;

  modport source (output valid, output sample_offset, input ready);
  modport sink   (input valid, input sample_offset, output ready);
endinterface

[design/ikw_weight_if.sv]
// Output channel of the kernel weight block: one Q2.14 weight per word.
// Depends on ikw_pkg for the field width.
interface ikw_weight_if
  import ikw_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

[design/interp_kernel_weight.sv]
// Top level of the interpolation kernel weight block: a five-stage weight pipeline.
// Depends on ikw_pkg and on the channel interfaces ikw_offset_if and ikw_weight_if.

// The block turns each signed Q2.12 sample offset x into one signed Q2.14 kernel weight,
// with the kernel chosen by a three-bit select register: zero, Catmull-Rom, Bell,
// cubic B-spline or the triangle 1 - |x|/2 (unused codes give zero). It takes one word
// per cycle while the output is not stalled and returns the weights in order through
// the five register stages of the pipeline (operand setup, squarer, coefficient
// multiplier, rounding add, divide by six with saturation). Each stage holds its own
// valid bit and moves on whenever the stage after it is free, so bubbles are squeezed
// out during an output stall and new words keep coming in, until every stage is full,
// while a finished weight waits in the output register. Every kernel piece is written
// as u^2 * c + k over one common divisor 6 * 2^22, where u is |x| or 2 - |x|; the
// weight is that value rounded to nearest with ties away from zero and clamped to
// +/-1.0. Write the select register only while no word is in flight.
module interp_kernel_weight
  import ikw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SEL_W-1:0] cfg_wdata_i,
  ikw_offset_if.sink       offset_i,
  ikw_weight_if.source     weight_o
);

  // Kernel select register.
  logic [SEL_W-1:0] sel_q;

  // Valid bits of the five stages and their load enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  // Stage 1: operand, coefficient and constant term.
  logic        [A_W-1:0] u_d, u_q;
  logic signed [C_W-1:0] c_d, c1_q;
  logic signed [P_W-1:0] k_d, k1_q;

  // Stage 2: square.
  logic        [SQ_W-1:0] sq_d, sq_q;
  logic signed [C_W-1:0]  c2_q;
  logic signed [P_W-1:0]  k2_q;

  // Stage 3: product with the coefficient.
  logic signed [P_W-1:0] p_d, p_q;
  logic signed [P_W-1:0] k3_q;

  // Stage 4: rounded numerator with the power-of-two part of the divisor removed.
  logic [Y_W-1:0] y_d, y_q;
  logic           neg_d, neg_q;

  // Stage 5: weight.
  logic signed [OUT_W-1:0] w_d, w_q;

  // Stage 1 locals.
  logic signed [IN_W:0]  x_ext;
  logic signed [IN_W:0]  x_neg;
  logic [A_W-1:0]        a_mag;
  logic [A_W-1:0]        t_mag;
  logic [A_W+1:0]        a_x3;
  logic signed [C_W-1:0] a_c, t_c;
  logic signed [P_W-1:0] a_p, t_p;
  logic                  in_inner, in_support, bell_inner;

  // Stage 4 and 5 locals.
  logic signed [P_W-1:0] n_sum, n_mag, n_rnd;
  logic [H_W-1:0]        h_val;
  logic [DIV_W-1:0]      div_prod;
  logic [Q_W-1:0]        q_val, q_sat;

  // A stage loads when it is empty or the next stage takes its word this cycle.
  assign en5 = !v5_q || weight_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign offset_i.ready  = en1;
  assign weight_o.valid  = v5_q;
  assign weight_o.weight = w_q;

  // Stage 1: magnitude of x, piece choice and the terms of u^2 * c + k.
  always_comb begin
    x_ext      = {offset_i.sample_offset[IN_W-1], offset_i.sample_offset};
    x_neg      = -x_ext;
    a_mag      = x_ext[IN_W] ? x_neg[A_W-1:0] : x_ext[A_W-1:0];
    t_mag      = A_W'(2 * S) - a_mag;
    a_x3       = (A_W + 2)'(3 * {2'b00, a_mag});
    a_c        = $signed({{(C_W - A_W){1'b0}}, a_mag});
    t_c        = $signed({{(C_W - A_W){1'b0}}, t_mag});
    a_p        = $signed({{(P_W - A_W){1'b0}}, a_mag});
    t_p        = $signed({{(P_W - A_W){1'b0}}, t_mag});
    in_inner   = a_mag < A_W'(S);
    in_support = a_mag < A_W'(2 * S);
    bell_inner = a_x3 <= (A_W + 2)'(2 * S);
    u_d        = '0;
    c_d        = '0;
    k_d        = '0;
    unique case (kernel_e'(sel_q))
      KERN_CATROM: begin
        u_d = a_mag;
        if (in_inner) begin
          c_d = C_W'(9 * a_c - 15 * S);
          k_d = CR_IN_OFF;
        end else if (in_support) begin
          c_d = C_W'(15 * S - 3 * a_c);
          k_d = P_W'((12 * S - 24 * a_p) <<< (2 * IN_FRAC_BITS));
        end
      end
      KERN_BSPLINE: begin
        if (in_inner) begin
          u_d = a_mag;
          c_d = C_W'(3 * a_c - 6 * S);
          k_d = BS_IN_OFF;
        end else if (in_support) begin
          // Outer piece is (2 - |x|)^3 / 6.
          u_d = t_mag;
          c_d = t_c;
        end
      end
      KERN_BELL: begin
        if (bell_inner) begin
          u_d = a_mag;
          c_d = BELL_IN_C;
          k_d = BELL_IN_OFF;
        end else if (a_mag <= A_W'(2 * S)) begin
          u_d = t_mag;
          c_d = BELL_OUT_C;
        end
      end
      KERN_TRI: begin
        // Linear in |x|: only the constant term is used.
        k_d = P_W'((3 * t_p) <<< (2 * IN_FRAC_BITS));
      end
      default: begin
        u_d = '0;
      end
    endcase
  end

  // Stage 2: square of the operand.
  assign sq_d = SQ_W'(SQ_W'(u_q) * SQ_W'(u_q));

  // Stage 3: signed product of the square and the coefficient.
  assign p_d = P_W'(P_W'($signed({1'b0, sq_q})) * P_W'(c2_q));

  // Stage 4: add the constant term, take the magnitude, add half the divisor and drop
  // its power-of-two factor.
  always_comb begin
    n_sum = p_q + k3_q;
    neg_d = n_sum[P_W-1];
    n_mag = neg_d ? -n_sum : n_sum;
    n_rnd = n_mag + HALF_DEN;
    y_d   = n_rnd[P_W-1:DEN_SHIFT];
  end

  // Stage 5: divide by six as a halving and a reciprocal multiply, then saturate and
  // restore the sign.
  always_comb begin
    h_val    = y_q[Y_W-1:1];
    div_prod = DIV_W'(DIV_W'(h_val) * DIV_W'(RECIP3));
    q_val    = div_prod[RECIP3_SHIFT +: Q_W];
    q_sat    = (q_val > Q_W'(SAT_LIM)) ? Q_W'(SAT_LIM) : q_val;
    w_d      = neg_q ? -OUT_W'(q_sat) : OUT_W'(q_sat);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_W'(KERN_ZERO);
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      if (en1) begin
        v1_q <= offset_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  // Payload registers load only when a valid word moves in.
  always_ff @(posedge clk_i) begin
    if (en1 && offset_i.valid) begin
      u_q  <= u_d;
      c1_q <= c_d;
      k1_q <= k_d;
    end
    if (en2 && v1_q) begin
      sq_q <= sq_d;
      c2_q <= c1_q;
      k2_q <= k1_q;
    end
    if (en3 && v2_q) begin
      p_q  <= p_d;
      k3_q <= k2_q;
    end
    if (en4 && v3_q) begin
      y_q   <= y_d;
      neg_q <= neg_d;
    end
    if (en5 && v4_q) begin
      w_q <= w_d;
    end
  end

endmodule
